// ===== hdl/calendar_schedule_matcher_macros.svh =====
// Assertion macros for the calendar schedule matcher
`ifndef CALENDAR_SCHEDULE_MATCHER_MACROS_SVH
`define CALENDAR_SCHEDULE_MATCHER_MACROS_SVH

// same-cycle implication
`define CSM_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CSM_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/csm_pkg.sv =====
// Shared types, constants and a helper function of the calendar schedule matcher
package csm_pkg;

   localparam int MAX_ENTRIES  = 16;
   localparam int SCAN_DAYS    = 371;
   localparam int IDX_W        = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W        = 5;
   localparam int SDAY_W       = $clog2(SCAN_DAYS + 1);
   localparam int SECS_PER_DAY = 86400;
   localparam int DIV_STEPS    = 16;
   localparam int TIME_W       = 35;
   localparam int DAY_W        = 16;
   localparam int TOD_W        = 17;
   localparam int RES_W        = 5;
   localparam int MAX_DUR      = 3600;

   // floor(x / 86400) = ((x >> RECIP_PRE) * RECIP) >> RECIP_SH for x below 2**33
   localparam int RECIP_PRE    = 7;
   localparam int RECIP        = 101806633;
   localparam int RECIP_SH     = 36;
   localparam int PROD_W       = 53;

   typedef enum logic [1:0] {
      ACT_WRITE = 2'd0,
      ACT_FIND  = 2'd1,
      ACT_WAIT  = 2'd2
   } csm_action_type;

   typedef enum logic [1:0] {
      MODE_DAILY    = 2'd0,
      MODE_INTERVAL = 2'd1,
      MODE_WEEKDAY  = 2'd2
   } csm_mode_type;

   typedef enum logic [1:0] {
      REG_TABLE_VALID   = 2'd0,
      REG_TZ_OFFSET     = 2'd1,
      REG_ENTRY_COUNT   = 2'd2,
      REG_DEFAULT_SLEEP = 2'd3
   } csm_reg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_PREP,
      ST_RUN,
      ST_FINISH
   } csm_state_type;

   typedef struct packed {
      logic [TOD_W-1:0] tod;
      logic [11:0]      dur;
      logic [31:0]      ch;
      logic [1:0]       mode;
      logic [4:0]       iv;
      logic [6:0]       wd;
      logic [15:0]      anchor;
   } csm_entry_type;

   typedef struct packed {
      logic                     vld;
      logic                     found;
      logic [DAY_W-1:0]         day;
      logic [2:0]               wd;
      logic signed [TIME_W-1:0] base;
      logic signed [TIME_W-1:0] best;
      logic [IDX_W-1:0]         sel;
      logic [11:0]              dur;
      logic [31:0]              ch;
   } csm_tok_type;

   typedef struct packed {
      logic             wr;
      logic [IDX_W-1:0] wr_idx;
      csm_entry_type    entry;
      logic             clr;
      logic             step;
      logic             qbit;
      logic             abit_en;
      logic [3:0]       abit_sel;
      logic             prep;
      logic             wait_q;
      logic [31:0]      now;
      logic [31:0]      last;
      logic [CNT_W-1:0] count;
      logic             flush;
   } csm_ctl_type;

   typedef struct packed {
      logic        found;
      logic [3:0]  due_index;
      logic [31:0] due_time_utc;
      logic [11:0] due_duration;
      logic [31:0] due_channels;
      logic [31:0] wait_seconds;
   } csm_rsp_type;

   // one MSB-first step of a remainder by m
   function automatic logic [RES_W-1:0] mod_step(input logic [RES_W-1:0] r, input logic b,
                                                 input logic [RES_W-1:0] m);
      logic [RES_W:0] t;
      t = {r, b};
      if (t >= {1'b0, m})
         t = t - {1'b0, m};
      return t[RES_W-1:0];
   endfunction

endpackage

// ===== hdl/csm_channel_if.sv =====
// Request and response channel interfaces
interface csm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  action;
   logic [31:0] now_utc;
   logic [31:0] last_run_utc;
   logic [3:0]  entry_index;
   logic [4:0]  entry_hour;
   logic [5:0]  entry_minute;
   logic [11:0] entry_duration;
   logic [31:0] entry_channels;
   logic [1:0]  entry_mode;
   logic [4:0]  entry_interval;
   logic [6:0]  entry_weekdays;
   logic [15:0] entry_anchor_day;

   modport source (output valid, action, now_utc, last_run_utc, entry_index, entry_hour,
                   entry_minute, entry_duration, entry_channels, entry_mode,
                   entry_interval, entry_weekdays, entry_anchor_day, input ready);
   modport sink (input valid, action, now_utc, last_run_utc, entry_index, entry_hour,
                 entry_minute, entry_duration, entry_channels, entry_mode,
                 entry_interval, entry_weekdays, entry_anchor_day, output ready);
endinterface

interface csm_rsp_if;
   logic        valid;
   logic        ready;
   logic        found;
   logic [3:0]  due_index;
   logic [31:0] due_time_utc;
   logic [11:0] due_duration;
   logic [31:0] due_channels;
   logic [31:0] wait_seconds;

   modport source (output valid, found, due_index, due_time_utc, due_duration,
                   due_channels, wait_seconds, input ready);
   modport sink (input valid, found, due_index, due_time_utc, due_duration,
                 due_channels, wait_seconds, output ready);
endinterface

// ===== hdl/csm_cell.sv =====
// One table slot: stored entry, day residue and a token stage of the scan chain
module csm_cell (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [csm_pkg::IDX_W-1:0]  cell_idx,
   input  csm_pkg::csm_ctl_type       ctl,
   input  csm_pkg::csm_tok_type       tok_in,
   output csm_pkg::csm_tok_type       tok_out
);

   csm_pkg::csm_entry_type          ent_ff;
   logic [csm_pkg::RES_W-1:0]       dm_ff, dm_in;
   logic [csm_pkg::RES_W-1:0]       am_ff, am_in;
   logic [csm_pkg::RES_W-1:0]       res_ff, res_in;
   csm_pkg::csm_tok_type            tok_ff, tok_in_nxt;
   logic                            en, match, time_ok, better, take;
   logic signed [csm_pkg::TIME_W-1:0] ep, now_s, last_s;
   logic [csm_pkg::RES_W:0]         res_inc, res_diff;

   always_ff @(posedge clock) begin
      if (ctl.wr && ctl.wr_idx == cell_idx) begin
         ent_ff <= ctl.entry;
      end
   end

   always_comb begin
      dm_in = dm_ff;
      am_in = am_ff;
      if (ctl.clr) begin
         dm_in = '0;
         am_in = '0;
      end else if (ctl.step) begin
         dm_in = csm_pkg::mod_step(dm_ff, ctl.qbit, ent_ff.iv);
         if (ctl.abit_en) begin
            am_in = csm_pkg::mod_step(am_ff, ent_ff.anchor[ctl.abit_sel], ent_ff.iv);
         end
      end
   end

   // residue of (day - anchor) modulo interval for the next token to arrive
   always_comb begin
      res_inc  = {1'b0, res_ff} + 1'b1;
      res_diff = {1'b0, dm_ff} + {1'b0, ent_ff.iv} - {1'b0, am_ff};
      res_in   = res_ff;
      if (ctl.prep) begin
         res_in = (dm_ff >= am_ff) ? (dm_ff - am_ff) : res_diff[csm_pkg::RES_W-1:0];
      end else if (tok_in.vld && !ctl.flush) begin
         res_in = (res_inc == {1'b0, ent_ff.iv}) ? '0 : res_inc[csm_pkg::RES_W-1:0];
      end
   end

   always_comb begin
      en     = csm_pkg::CNT_W'(cell_idx) < ctl.count;
      ep     = tok_in.base + $signed({{(csm_pkg::TIME_W-csm_pkg::TOD_W){1'b0}}, ent_ff.tod});
      now_s  = $signed({{(csm_pkg::TIME_W-32){1'b0}}, ctl.now});
      last_s = $signed({{(csm_pkg::TIME_W-32){1'b0}}, ctl.last});
      case (ent_ff.mode)
         csm_pkg::MODE_INTERVAL: match = (tok_in.day >= ent_ff.anchor) && (res_ff == '0);
         csm_pkg::MODE_WEEKDAY:  match = ent_ff.wd[tok_in.wd];
         default:                match = 1'b1;
      endcase
      if (ctl.wait_q) begin
         time_ok = ep > now_s;
         better  = !tok_in.found || (ep < tok_in.best);
      end else begin
         time_ok = (ep <= now_s) && (ep > last_s);
         better  = !tok_in.found || (ep > tok_in.best);
      end
      take = tok_in.vld && en && match && time_ok && better;
      tok_in_nxt = tok_in;
      if (take) begin
         tok_in_nxt.found = 1'b1;
         tok_in_nxt.best  = ep;
         tok_in_nxt.sel   = cell_idx;
         tok_in_nxt.dur   = ent_ff.dur;
         tok_in_nxt.ch    = ent_ff.ch;
      end
      if (ctl.flush) begin
         tok_in_nxt.vld = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      dm_ff  <= dm_in;
      am_ff  <= am_in;
      res_ff <= res_in;
      if (reset) begin
         tok_ff.vld <= 1'b0;
      end else begin
         tok_ff.vld <= tok_in_nxt.vld;
      end
      tok_ff.found <= tok_in_nxt.found;
      tok_ff.day   <= tok_in_nxt.day;
      tok_ff.wd    <= tok_in_nxt.wd;
      tok_ff.base  <= tok_in_nxt.base;
      tok_ff.best  <= tok_in_nxt.best;
      tok_ff.sel   <= tok_in_nxt.sel;
      tok_ff.dur   <= tok_in_nxt.dur;
      tok_ff.ch    <= tok_in_nxt.ch;
   end

   assign tok_out = tok_ff;

endmodule

// ===== hdl/csm_ctrl.sv =====
// Sequencer: registers, request decode, day split, day launch and response
`include "calendar_schedule_matcher_macros.svh"

module csm_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   csm_req_if.sink               req_ch,
   csm_rsp_if.source             rsp_ch,
   input  logic                  csr_we,
   input  logic [1:0]            csr_index,
   input  logic [31:0]           csr_wdata,
   output csm_pkg::csm_ctl_type  ctl,
   output csm_pkg::csm_tok_type  tok_launch,
   input  csm_pkg::csm_tok_type  tok_end
);

   csm_pkg::csm_state_type state_ff, state_in;

   logic                           tv_ff;
   logic signed [16:0]             tz_ff;
   logic [csm_pkg::CNT_W-1:0]      cnt_ff;
   logic [31:0]                    sleep_ff;

   logic [1:0]                     act_ff;
   logic [31:0]                    now_ff, last_ff;
   logic [32:0]                    loc_ff;
   logic [csm_pkg::PROD_W-1:0]     prod_ff;
   logic [csm_pkg::DAY_W-1:0]      day_ff;
   logic [2:0]                     wd_ff;
   logic [5:0]                     stp_ff;
   logic signed [csm_pkg::TIME_W-1:0] base_ff;
   logic [csm_pkg::SDAY_W-1:0]     nl_ff, nx_ff;
   csm_pkg::csm_rsp_type           pend_ff, rd_ff;
   logic                           rv_ff;

   logic                           accept, legal, trivial, is_wait, launch, done;
   logic signed [csm_pkg::TIME_W-1:0] loc_s, now_s;
   logic [32:0]                    loc_clamp;
   logic [25:0]                    mul_a;
   logic [26:0]                    mul_b;
   logic [csm_pkg::DAY_W-1:0]      day_q;
   logic [32:0]                    ds_calc;
   logic                           qbit;
   logic [csm_pkg::SDAY_W-1:0]     ndays;
   logic [5:0]                     m7_s1;
   logic [3:0]                     m7_s2, wd_sum;
   logic [2:0]                     m7, wd_start;
   csm_pkg::csm_entry_type         entry;
   csm_pkg::csm_rsp_type           miss_rsp, hit_rsp;

   // request decode and datapath helpers
   always_comb begin
      accept  = req_ch.valid && req_ch.ready;
      is_wait = act_ff == csm_pkg::ACT_WAIT;
      legal   = (32'(req_ch.entry_index) < 32'(csm_pkg::MAX_ENTRIES))
                && (req_ch.entry_hour <= 5'd23) && (req_ch.entry_minute <= 6'd59)
                && (req_ch.entry_duration != '0) && (req_ch.entry_channels != '0);
      trivial = !tv_ff || ((req_ch.action == csm_pkg::ACT_WAIT) && (cnt_ff == '0));
      loc_s   = $signed({3'b000, req_ch.now_utc}) + $signed({{18{tz_ff[16]}}, tz_ff});
      loc_clamp = loc_s[csm_pkg::TIME_W-1] ? '0 : loc_s[32:0];
      now_s   = $signed({3'b000, now_ff});
      // local day number by reciprocal multiplication
      mul_a   = loc_ff[32:csm_pkg::RECIP_PRE];
      mul_b   = 27'(csm_pkg::RECIP);
      day_q   = prod_ff[csm_pkg::RECIP_SH +: csm_pkg::DAY_W];
      ds_calc = 33'(day_q) * 33'(csm_pkg::SECS_PER_DAY);
      qbit    = day_q[~stp_ff[3:0]];
      // day modulo 7 by folding octal digits
      m7_s1   = 6'(day_q[2:0]) + 6'(day_q[5:3]) + 6'(day_q[8:6]) + 6'(day_q[11:9])
                + 6'(day_q[14:12]) + 6'(day_q[15]);
      m7_s2   = 4'(m7_s1[2:0]) + 4'(m7_s1[5:3]);
      m7      = (m7_s2 >= 4'd7) ? 3'(m7_s2 - 4'd7) : m7_s2[2:0];
      wd_sum  = {1'b0, m7} + 4'd4;
      wd_start = (wd_sum >= 4'd7) ? 3'(wd_sum - 4'd7) : wd_sum[2:0];
      ndays   = (act_ff == csm_pkg::ACT_FIND) ? csm_pkg::SDAY_W'(1)
                                                : csm_pkg::SDAY_W'(csm_pkg::SCAN_DAYS);
      launch  = (state_ff == csm_pkg::ST_RUN) && (nl_ff < ndays);
      done    = (state_ff == csm_pkg::ST_RUN) && tok_end.vld
                && (tok_end.found || (nx_ff + 1'b1 == ndays));

      entry.tod    = csm_pkg::TOD_W'(32'(req_ch.entry_hour) * 3600
                                     + 32'(req_ch.entry_minute) * 60);
      entry.dur    = (req_ch.entry_duration > 12'(csm_pkg::MAX_DUR))
                     ? 12'(csm_pkg::MAX_DUR) : req_ch.entry_duration;
      entry.ch     = req_ch.entry_channels;
      entry.mode   = csm_pkg::MODE_DAILY;
      entry.iv     = 5'd1;
      entry.wd     = '0;
      entry.anchor = '0;
      if (req_ch.entry_mode == csm_pkg::MODE_INTERVAL) begin
         entry.mode   = csm_pkg::MODE_INTERVAL;
         entry.iv     = (req_ch.entry_interval == '0) ? 5'd1 : req_ch.entry_interval;
         entry.anchor = req_ch.entry_anchor_day;
      end else if ((req_ch.entry_mode == csm_pkg::MODE_WEEKDAY)
                   && (req_ch.entry_weekdays != '0)) begin
         entry.mode   = csm_pkg::MODE_WEEKDAY;
         entry.wd     = req_ch.entry_weekdays;
         entry.anchor = req_ch.entry_anchor_day;
      end

      miss_rsp = '0;
      if (is_wait) begin
         miss_rsp.wait_seconds = sleep_ff;
      end
      hit_rsp = '0;
      hit_rsp.found = 1'b1;
      if (is_wait) begin
         hit_rsp.wait_seconds = 32'(tok_end.best - now_s);
      end else begin
         hit_rsp.due_index    = 4'(tok_end.sel);
         hit_rsp.due_time_utc = tok_end.best[31:0];
         hit_rsp.due_duration = tok_end.dur;
         hit_rsp.due_channels = tok_end.ch;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         csm_pkg::ST_IDLE: begin
            if (accept) begin
               if (((req_ch.action == csm_pkg::ACT_FIND)
                    || (req_ch.action == csm_pkg::ACT_WAIT)) && !trivial) begin
                  state_in = csm_pkg::ST_MUL;
               end else begin
                  state_in = csm_pkg::ST_FINISH;
               end
            end
         end
         csm_pkg::ST_MUL: state_in = csm_pkg::ST_DIV;
         csm_pkg::ST_DIV: begin
            if (stp_ff == 6'(csm_pkg::DIV_STEPS - 1)) begin
               state_in = csm_pkg::ST_PREP;
            end
         end
         csm_pkg::ST_PREP: state_in = csm_pkg::ST_RUN;
         csm_pkg::ST_RUN: begin
            if (done) begin
               state_in = csm_pkg::ST_FINISH;
            end
         end
         csm_pkg::ST_FINISH: begin
            if (!rv_ff || rsp_ch.ready) begin
               state_in = csm_pkg::ST_IDLE;
            end
         end
         default: state_in = csm_pkg::ST_IDLE;
      endcase
   end

   // outputs to the cells and the request side
   always_comb begin
      req_ch.ready = state_ff == csm_pkg::ST_IDLE;
      ctl          = '0;
      ctl.wr       = (state_ff == csm_pkg::ST_IDLE) && req_ch.valid
                     && (req_ch.action == csm_pkg::ACT_WRITE) && legal;
      ctl.wr_idx   = csm_pkg::IDX_W'(req_ch.entry_index);
      ctl.entry    = entry;
      ctl.clr      = (state_ff == csm_pkg::ST_IDLE) && req_ch.valid
                     && !trivial && ((req_ch.action == csm_pkg::ACT_FIND)
                                     || (req_ch.action == csm_pkg::ACT_WAIT));
      ctl.step     = state_ff == csm_pkg::ST_DIV;
      ctl.qbit     = qbit;
      ctl.abit_en  = stp_ff < 6'd16;
      ctl.abit_sel = ~stp_ff[3:0];
      ctl.prep     = state_ff == csm_pkg::ST_PREP;
      ctl.wait_q   = is_wait;
      ctl.now      = now_ff;
      ctl.last     = last_ff;
      ctl.count    = cnt_ff;
      ctl.flush    = done;

      tok_launch       = '0;
      tok_launch.vld   = launch;
      tok_launch.day   = day_ff;
      tok_launch.wd    = wd_ff;
      tok_launch.base  = base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= csm_pkg::ST_IDLE;
         tv_ff    <= 1'b1;
         tz_ff    <= 17'sd32400;
         cnt_ff   <= '0;
         sleep_ff <= 32'd3600;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_we) begin
            unique case (csr_index)
               csm_pkg::REG_TABLE_VALID:   tv_ff    <= csr_wdata[0];
               csm_pkg::REG_TZ_OFFSET:     tz_ff    <= $signed(csr_wdata[16:0]);
               csm_pkg::REG_ENTRY_COUNT:   cnt_ff   <= csr_wdata[csm_pkg::CNT_W-1:0];
               csm_pkg::REG_DEFAULT_SLEEP: sleep_ff <= csr_wdata;
               default: ;
            endcase
         end
         if ((state_ff == csm_pkg::ST_FINISH) && (!rv_ff || rsp_ch.ready)) begin
            rv_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rv_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == csm_pkg::ST_FINISH && (!rv_ff || rsp_ch.ready)) begin
         rd_ff <= pend_ff;
      end
      unique case (state_ff)
         csm_pkg::ST_IDLE: begin
            act_ff  <= req_ch.action;
            now_ff  <= req_ch.now_utc;
            last_ff <= req_ch.last_run_utc;
            loc_ff  <= loc_clamp;
            stp_ff  <= '0;
            pend_ff <= '0;
            if (trivial && (req_ch.action == csm_pkg::ACT_WAIT)) begin
               pend_ff.wait_seconds <= sleep_ff;
            end
         end
         csm_pkg::ST_MUL: begin
            prod_ff <= csm_pkg::PROD_W'(mul_a) * csm_pkg::PROD_W'(mul_b);
         end
         csm_pkg::ST_DIV: begin
            stp_ff <= stp_ff + 1'b1;
         end
         csm_pkg::ST_PREP: begin
            base_ff <= $signed({2'b00, ds_calc}) - $signed({{18{tz_ff[16]}}, tz_ff});
            day_ff  <= day_q;
            wd_ff   <= wd_start;
            nl_ff   <= '0;
            nx_ff   <= '0;
         end
         csm_pkg::ST_RUN: begin
            if (launch) begin
               nl_ff   <= nl_ff + 1'b1;
               day_ff  <= day_ff + 1'b1;
               wd_ff   <= (wd_ff == 3'd6) ? 3'd0 : wd_ff + 3'd1;
               base_ff <= base_ff + csm_pkg::TIME_W'(csm_pkg::SECS_PER_DAY);
            end
            if (tok_end.vld) begin
               nx_ff <= nx_ff + 1'b1;
            end
            if (done) begin
               pend_ff <= tok_end.found ? hit_rsp : miss_rsp;
            end
         end
         default: ;
      endcase
   end

   assign rsp_ch.valid        = rv_ff;
   assign rsp_ch.found        = rd_ff.found;
   assign rsp_ch.due_index    = rd_ff.due_index;
   assign rsp_ch.due_time_utc = rd_ff.due_time_utc;
   assign rsp_ch.due_duration = rd_ff.due_duration;
   assign rsp_ch.due_channels = rd_ff.due_channels;
   assign rsp_ch.wait_seconds = rd_ff.wait_seconds;

   `CSM_ASSERT_IMP(a_tok_only_in_run, tok_end.vld, state_ff == csm_pkg::ST_RUN, "token outside scan")
   `CSM_ASSERT_IMP(a_launch_bound, state_ff == csm_pkg::ST_RUN, nl_ff <= ndays, "too many days launched")
   `CSM_ASSERT_IMP(a_div_bound, state_ff == csm_pkg::ST_DIV, stp_ff < 6'(csm_pkg::DIV_STEPS), "residue step overrun")
   `CSM_ASSERT_NXT(a_prep_to_run, state_ff == csm_pkg::ST_PREP, state_ff == csm_pkg::ST_RUN, "prep not followed by scan")

endmodule

// ===== hdl/calendar_schedule_matcher.sv =====
// Top level: sequencer and the chain of table slot cells
//
//  channel  direction  handshake            carries
//  req_ch   in         valid/ready          action, times, entry fields
//  rsp_ch   out        valid/ready          found, due entry, wait seconds
//  csr      in         csr_we (no stall)    index 0..3, 32 bit data
//
// Write, trivial and undefined requests go from idle straight to the response state.
// Find: a reciprocal multiply, 16 residue steps and a setup state, then one token
// through MAX_ENTRIES cells. Wait: one token per further scanned day, up to SCAN_DAYS days.
// One request is in work at a time; the response register lets the next request
// in while a response waits. Synchronous reset restores the register defaults;
// table contents are undefined until written.
module calendar_schedule_matcher (
   input  logic        clock,
   input  logic        reset,
   csm_req_if.sink     req_ch,
   csm_rsp_if.source   rsp_ch,
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [31:0] csr_wdata
);

   csm_pkg::csm_ctl_type ctl;
   csm_pkg::csm_tok_type chain [csm_pkg::MAX_ENTRIES+1];

   csm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .rsp_ch     (rsp_ch),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .ctl        (ctl),
      .tok_launch (chain[0]),
      .tok_end    (chain[csm_pkg::MAX_ENTRIES])
   );

   for (genvar i = 0; i < csm_pkg::MAX_ENTRIES; i++) begin : g_cell
      csm_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_idx (csm_pkg::IDX_W'(i)),
         .ctl      (ctl),
         .tok_in   (chain[i]),
         .tok_out  (chain[i+1])
      );
   end

endmodule

// ===== sim/calendar_schedule_matcher_tb.sv =====
// Testbench for the calendar schedule matcher: directed table, random requests, predictor
module calendar_schedule_matcher_tb;

   localparam int  LIMIT     = 2000000;
   localparam int  DRAIN     = 600;
   localparam int  SLOTS     = 16;
   localparam int  SECS      = 86400;
   localparam int  NUM_DIR   = 23;

   typedef struct packed {
      logic [1:0]  action;
      logic [31:0] now;
      logic [31:0] last;
      logic [3:0]  idx;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [11:0] dur;
      logic [31:0] ch;
      logic [1:0]  mode;
      logic [4:0]  iv;
      logic [6:0]  wd;
      logic [15:0] anchor;
   } request_type;

   typedef struct {
      request_type          req;
      bit                   typed;
      csm_pkg::csm_rsp_type rsp;
   } dir_row_type;

   logic        clock = 0;
   logic        reset = 1;
   logic        csr_we = 0;
   logic [1:0]  csr_index = '0;
   logic [31:0] csr_wdata = '0;

   csm_req_if req_bus ();
   csm_rsp_if rsp_bus ();

   calendar_schedule_matcher u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_bus),
      .rsp_ch    (rsp_bus),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // predicted state
   logic [4:0]            slot_hour [SLOTS];
   logic [5:0]            slot_min [SLOTS];
   logic [11:0]           slot_dur [SLOTS];
   logic [31:0]           slot_ch [SLOTS];
   csm_pkg::csm_mode_type slot_mode [SLOTS];
   logic [4:0]            slot_iv [SLOTS];
   logic [6:0]            slot_wd [SLOTS];
   logic [15:0]           slot_anchor [SLOTS];
   bit                    sched_valid;
   longint                tz_offset;
   logic [4:0]            used_entries;
   logic [31:0]           sleep_secs;

   csm_pkg::csm_rsp_type  due_q[$];
   int                    errors = 0;
   int unsigned           cycles = 0;
   bit                    quiet = 0;
   dir_row_type           dir_rows [NUM_DIR];

   function automatic bit rule_hit(int i, longint day);
      longint elapsed, wday;
      if (slot_mode[i] == csm_pkg::MODE_INTERVAL) begin
         elapsed = day - longint'(slot_anchor[i]);
         return elapsed >= 0 && (elapsed % longint'(slot_iv[i])) == 0;
      end
      if (slot_mode[i] == csm_pkg::MODE_WEEKDAY) begin
         wday = (day + 4) % 7;
         if (wday < 0) wday += 7;
         return slot_wd[i][wday];
      end
      return 1;
   endfunction

   function automatic longint day_base_of(logic [31:0] now);
      return ((longint'(now) + tz_offset) / SECS) * SECS;
   endfunction

   function automatic longint slot_time(int i, longint ds);
      return ds + longint'(slot_hour[i]) * 3600 + longint'(slot_min[i]) * 60 - tz_offset;
   endfunction

   function automatic csm_pkg::csm_rsp_type schedule_answer(request_type r);
      csm_pkg::csm_rsp_type res;
      longint       ds, day, ep, best, cds;
      int           n;
      bit           hit;
      res = '0;
      n = (used_entries > SLOTS) ? SLOTS : int'(used_entries);
      hit = 0;
      best = 0;
      case (r.action)
         csm_pkg::ACT_WRITE: begin
            if (r.hour <= 23 && r.minute <= 59 && r.dur != 0 && r.ch != 0) begin
               slot_hour[r.idx]   = r.hour;
               slot_min[r.idx]    = r.minute;
               slot_dur[r.idx]    = (r.dur > 3600) ? 12'd3600 : r.dur;
               slot_ch[r.idx]     = r.ch;
               slot_mode[r.idx]   = csm_pkg::MODE_DAILY;
               slot_iv[r.idx]     = 5'd1;
               slot_wd[r.idx]     = '0;
               slot_anchor[r.idx] = '0;
               if (r.mode == csm_pkg::MODE_INTERVAL) begin
                  slot_mode[r.idx]   = csm_pkg::MODE_INTERVAL;
                  slot_iv[r.idx]     = (r.iv == 0) ? 5'd1 : r.iv;
                  slot_anchor[r.idx] = r.anchor;
               end else if (r.mode == csm_pkg::MODE_WEEKDAY && r.wd != 0) begin
                  slot_mode[r.idx]   = csm_pkg::MODE_WEEKDAY;
                  slot_iv[r.idx]     = r.iv;
                  slot_wd[r.idx]     = r.wd;
                  slot_anchor[r.idx] = r.anchor;
               end
            end
         end
         csm_pkg::ACT_FIND: begin
            if (sched_valid) begin
               ds = day_base_of(r.now);
               day = ds / SECS;
               for (int i = 0; i < n; i++) begin
                  if (!rule_hit(i, day)) continue;
                  ep = slot_time(i, ds);
                  if (ep > longint'(r.now) || ep <= longint'(r.last)) continue;
                  if (!hit || ep > best) begin
                     hit = 1;
                     best = ep;
                     res.due_index = 4'(i);
                  end
               end
               if (hit) begin
                  res.found        = 1;
                  res.due_time_utc = best[31:0];
                  res.due_duration = slot_dur[res.due_index];
                  res.due_channels = slot_ch[res.due_index];
               end
            end
         end
         csm_pkg::ACT_WAIT: begin
            res.wait_seconds = sleep_secs;
            if (sched_valid && n != 0) begin
               ds = day_base_of(r.now);
               for (int d = 0; d < csm_pkg::SCAN_DAYS && !hit; d++) begin
                  cds = ds + longint'(d) * SECS;
                  for (int i = 0; i < n; i++) begin
                     if (!rule_hit(i, cds / SECS)) continue;
                     ep = slot_time(i, cds);
                     if (ep <= longint'(r.now)) continue;
                     if (!hit || ep < best) begin
                        hit = 1;
                        best = ep;
                     end
                  end
               end
               if (hit) begin
                  res.found        = 1;
                  best             = best - longint'(r.now);
                  res.wait_seconds = best[31:0];
               end
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   function automatic request_type mk(logic [1:0] a, logic [31:0] now, logic [31:0] last,
                                      logic [3:0] idx, logic [4:0] h, logic [5:0] m,
                                      logic [11:0] dur, logic [31:0] ch, logic [1:0] mode,
                                      logic [4:0] iv, logic [6:0] wd, logic [15:0] anchor);
      request_type r;
      r = '{a, now, last, idx, h, m, dur, ch, mode, iv, wd, anchor};
      return r;
   endfunction

   function automatic request_type random_request();
      request_type r;
      int unsigned pick, day;
      r = '0;
      pick = $urandom_range(0, 99);
      r.action = (pick < 25) ? csm_pkg::ACT_WRITE : (pick < 60) ? csm_pkg::ACT_FIND
                 : (pick < 96) ? csm_pkg::ACT_WAIT : 2'd3;
      day = $urandom_range(19000, 19100);
      r.now = ($urandom_range(0, 9) == 0) ? $urandom() : day * SECS + $urandom_range(0, SECS);
      case ($urandom_range(0, 3))
         0: r.last = $urandom();
         1: r.last = r.now;
         default: r.last = r.now - $urandom_range(0, 2 * SECS);
      endcase
      r.idx    = 4'($urandom());
      r.hour   = 5'($urandom_range(0, 23));
      r.minute = 6'($urandom_range(0, 59));
      r.dur    = 12'($urandom_range(1, 4095));
      r.ch     = $urandom() | 32'd1;
      r.mode   = 2'($urandom_range(0, 3));
      r.iv     = 5'($urandom());
      r.wd     = 7'($urandom());
      r.anchor = 16'($urandom_range(18990, 19100));
      if ($urandom_range(0, 9) == 0) begin
         r.hour   = 5'($urandom());
         r.minute = 6'($urandom());
         r.dur    = 12'($urandom());
         r.ch     = $urandom() & {32{$urandom_range(0, 1) == 1'b1}};
         r.anchor = 16'($urandom());
      end
      return r;
   endfunction

   task automatic send(request_type r, bit typed, csm_pkg::csm_rsp_type typed_rsp);
      csm_pkg::csm_rsp_type p;
      if (!quiet && $urandom_range(0, 99) < 10) begin
         req_bus.valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_bus.valid            <= 1'b1;
      req_bus.action           <= r.action;
      req_bus.now_utc          <= r.now;
      req_bus.last_run_utc     <= r.last;
      req_bus.entry_index      <= r.idx;
      req_bus.entry_hour       <= r.hour;
      req_bus.entry_minute     <= r.minute;
      req_bus.entry_duration   <= r.dur;
      req_bus.entry_channels   <= r.ch;
      req_bus.entry_mode       <= r.mode;
      req_bus.entry_interval   <= r.iv;
      req_bus.entry_weekdays   <= r.wd;
      req_bus.entry_anchor_day <= r.anchor;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      p = schedule_answer(r);
      due_q.push_back(typed ? typed_rsp : p);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (due_q.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
   endtask

   task automatic write_regs(bit v, int tz, logic [4:0] cnt, logic [31:0] slp);
      logic [31:0] vals [4];
      vals = '{{31'd0, v}, 32'(tz), {27'd0, cnt}, slp};
      for (int i = 0; i < 4; i++) begin
         csr_we    <= 1'b1;
         csr_index <= 2'(i);
         csr_wdata <= vals[i];
         @(posedge clock);
      end
      csr_we <= 1'b0;
      sched_valid  = v;
      tz_offset    = tz;
      used_entries = cnt;
      sleep_secs   = slp;
   endtask

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_bus.ready <= quiet ? 1'b1 : ($urandom_range(0, 99) >= 10);
   end

   always @(posedge clock) begin
      csm_pkg::csm_rsp_type got, want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.found, rsp_bus.due_index, rsp_bus.due_time_utc,
                 rsp_bus.due_duration, rsp_bus.due_channels, rsp_bus.wait_seconds};
         if (due_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response %p", got);
         end else begin
            want = due_q.pop_front();
            if (got.found !== want.found || got.due_index !== want.due_index ||
                got.due_time_utc !== want.due_time_utc ||
                got.due_duration !== want.due_duration ||
                got.due_channels !== want.due_channels ||
                got.wait_seconds !== want.wait_seconds) begin
               errors++;
               if (errors <= 10) $display("mismatch: expected %p got %p", want, got);
            end
         end
      end
   end

   initial begin
      csm_pkg::csm_rsp_type zero, sleep0;
      request_type r;
      int          tz_pick;
      req_bus.valid = 1'b0;
      req_bus.action = '0; req_bus.now_utc = '0; req_bus.last_run_utc = '0;
      req_bus.entry_index = '0; req_bus.entry_hour = '0; req_bus.entry_minute = '0;
      req_bus.entry_duration = '0; req_bus.entry_channels = '0; req_bus.entry_mode = '0;
      req_bus.entry_interval = '0; req_bus.entry_weekdays = '0;
      req_bus.entry_anchor_day = '0;
      rsp_bus.ready = 1'b0;
      sched_valid = 1; tz_offset = 32400; used_entries = 0; sleep_secs = 3600;
      zero = '0;
      sleep0 = '0;
      sleep0.wait_seconds = 3600;

      // after reset: empty table, then every slot written, then bad writes
      dir_rows[0]  = '{mk(csm_pkg::ACT_WAIT, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, sleep0};
      dir_rows[1]  = '{mk(csm_pkg::ACT_FIND, '1, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0), 1, zero};
      dir_rows[2]  = '{mk(2'd3, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1, '1), 1, zero};
      dir_rows[3]  = '{mk(csm_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 1, 1, csm_pkg::MODE_DAILY,
                          0, 0, 0), 1, zero};
      dir_rows[4]  = '{mk(csm_pkg::ACT_WRITE, 0, 0, 1, 23, 59, '1, '1, csm_pkg::MODE_DAILY,
                          0, 0, 0), 1, zero};
      dir_rows[5]  = '{mk(csm_pkg::ACT_WRITE, 0, 0, 2, 6, 30, 3600, 5,
                          csm_pkg::MODE_INTERVAL, 0, 0, 19000), 1, zero};
      dir_rows[6]  = '{mk(csm_pkg::ACT_WRITE, 0, 0, 3, 7, 0, 3601, 2,
                          csm_pkg::MODE_INTERVAL, 31, 0, '1), 1, zero};
      dir_rows[7]  = '{mk(csm_pkg::ACT_WRITE, 0, 0, 4, 8, 15, 60, 3,
                          csm_pkg::MODE_WEEKDAY, 3, 0, 0), 1, zero};
      dir_rows[8]  = '{mk(csm_pkg::ACT_WRITE, 0, 0, 5, 9, 45, 120, 7,
                          csm_pkg::MODE_WEEKDAY, 0, 7'h7F, 5), 1, zero};
      dir_rows[9]  = '{mk(csm_pkg::ACT_WRITE, 0, 0, 6, 12, 0, 90, 8, 2'd3, 9, 7'h55, 7),
                       1, zero};
      dir_rows[10] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 7, 12, 0, 90, 9, csm_pkg::MODE_DAILY,
                          0, 0, 0), 1, zero};
      dir_rows[11] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 8, 5, 5, 10, 16,
                          csm_pkg::MODE_INTERVAL, 7, 0, 19020), 1, zero};
      dir_rows[12] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 9, 18, 20, 30, 32,
                          csm_pkg::MODE_WEEKDAY, 1, 7'h01, 0), 1, zero};
      dir_rows[13] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 10, 22, 10, 40, 64,
                          csm_pkg::MODE_WEEKDAY, 1, 7'h40, 0), 1, zero};
      dir_rows[14] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 11, 1, 1, 50, 128,
                          csm_pkg::MODE_INTERVAL, 2, 0, 19050), 1, zero};
      dir_rows[15] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 12, 3, 33, 70, 256,
                          csm_pkg::MODE_DAILY, 0, 0, 0), 1, zero};
      dir_rows[16] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 13, 14, 14, 80, 512,
                          csm_pkg::MODE_INTERVAL, 3, 0, 19060), 1, zero};
      dir_rows[17] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 14, 16, 40, 100, 1024,
                          csm_pkg::MODE_WEEKDAY, 0, 7'h2A, 0), 1, zero};
      dir_rows[18] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 15, 20, 0, 200, 2048,
                          csm_pkg::MODE_DAILY, 0, 0, 0), 1, zero};
      dir_rows[19] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 0, 24, 0, 1, 1, csm_pkg::MODE_DAILY,
                          0, 0, 0), 1, zero};
      dir_rows[20] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 0, 0, 60, 1, 1, csm_pkg::MODE_DAILY,
                          0, 0, 0), 1, zero};
      dir_rows[21] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, 1, csm_pkg::MODE_DAILY,
                          0, 0, 0), 1, zero};
      dir_rows[22] = '{mk(csm_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 1, 0, csm_pkg::MODE_DAILY,
                          0, 0, 0), 1, zero};

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < NUM_DIR; i++) send(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

      for (int ph = 0; ph < 7; ph++) begin
         settle();
         tz_pick = $urandom_range(0, 100800);
         case (ph)
            0: write_regs(1, 32400, 16, 3600);
            1: write_regs(1, -50400, 1, 0);
            2: write_regs(1, 50400, 8, '1);
            3: write_regs(0, 0, 16, 12345);
            4: write_regs(1, 0, 20, $urandom());
            5: write_regs(1, tz_pick - 50400, 0, $urandom());
            default: write_regs(1, tz_pick - 50400, 5'($urandom_range(1, 16)), $urandom());
         endcase
         quiet = (ph == 2);
         for (int k = 0; k < 12; k++) begin
            r = random_request();
            send(r, 0, zero);
         end
      end

      settle();
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/csm_pkg.sv
hdl/csm_channel_if.sv
hdl/csm_cell.sv
hdl/csm_ctrl.sv
hdl/calendar_schedule_matcher.sv
sim/calendar_schedule_matcher_tb.sv
